// ----- hw/rtl/fik_pkg.sv -----
// Shared types and constants for the two-link FABRIK solver.
package fik_pkg;

  localparam int CW = 48;   // internal signed coordinate width
  localparam int DW = 50;   // distance width
  localparam int PW = 79;   // magnitude times link length
  localparam int QW = 41;   // clamped quotient width
  localparam int LW = 31;   // link length / tolerance width

  localparam logic [1:0] CFG_LEN0 = 2'd0;
  localparam logic [1:0] CFG_LEN1 = 2'd1;
  localparam logic [1:0] CFG_TOL  = 2'd2;
  localparam logic [1:0] CFG_LIM  = 2'd3;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] elbow_x;
    logic signed [31:0] elbow_y;
    logic signed [31:0] elbow_z;
    logic signed [31:0] tip_x;
    logic signed [31:0] tip_y;
    logic signed [31:0] tip_z;
    logic               target_reachable;
    logic               converged;
  } out_t;

endpackage

// ----- hw/rtl/fabrik_two_link_ik_solver.sv -----
// Two-link FABRIK inverse-kinematics solver on one shared iterative datapath.
//
// A solve starts at a rising edge where start is high and busy is low, and
// busy stays high until the result is shown. The result sits on out_data for
// exactly one cycle with out_valid high and cannot be held off. All work runs
// through one sequenced datapath: a distance runs component setup, a
// normalizing shift one step a cycle, three squarings on one 30x30 multiplier
// and 32 square-root steps. Placing a point at a given distance takes a
// distance plus, per axis, 31 shift-add multiply steps and 41 restoring divide
// steps; an axis whose quotient saturates skips the divide steps. An
// unreachable target needs a distance and two placements; a reachable one
// two distances plus three placements and one distance per FABRIK pass, with
// at most the configured pass limit (CFG_LIM) of passes. Configuration
// writes take effect at once and are meant for idle time only.
module fabrik_two_link_ik_solver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fik_pkg::in_t       in_data,
  output logic               out_valid,
  output fik_pkg::out_t      out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int CW = fik_pkg::CW;
  localparam int DW = fik_pkg::DW;
  localparam int PW = fik_pkg::PW;
  localparam int QW = fik_pkg::QW;
  localparam int LW = fik_pkg::LW;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LAUNCH = 4'd1;
  localparam logic [3:0] ST_DIFF   = 4'd2;
  localparam logic [3:0] ST_MAX    = 4'd3;
  localparam logic [3:0] ST_NORM   = 4'd4;
  localparam logic [3:0] ST_SQ     = 4'd5;
  localparam logic [3:0] ST_ACC    = 4'd6;
  localparam logic [3:0] ST_ROOT   = 4'd7;
  localparam logic [3:0] ST_DEND   = 4'd8;
  localparam logic [3:0] ST_MUL    = 4'd9;
  localparam logic [3:0] ST_DVS    = 4'd10;
  localparam logic [3:0] ST_DIV    = 4'd11;
  localparam logic [3:0] ST_FIN    = 4'd12;
  localparam logic [3:0] ST_RET    = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;

  // solve steps
  localparam logic [2:0] M_D0 = 3'd0;  // root-to-target distance
  localparam logic [2:0] M_U1 = 3'd1;  // stretch elbow
  localparam logic [2:0] M_U2 = 3'd2;  // stretch tip
  localparam logic [2:0] M_G  = 3'd3;  // tip-to-target gap
  localparam logic [2:0] M_P1 = 3'd4;  // forward pass, elbow from target
  localparam logic [2:0] M_P2 = 3'd5;  // backward pass, elbow from root
  localparam logic [2:0] M_P3 = 3'd6;  // backward pass, tip from elbow

  localparam logic [63:0] ROOT_BIT = 64'h4000_0000_0000_0000;
  localparam logic [QW-1:0] QLIM = QW'(1) << (QW - 1);

  logic [3:0]  st_r;
  logic [2:0]  step_r;
  logic [LW-1:0] len0_r, len1_r, tol_r;
  logic [7:0]  lim_r, n_r;

  logic signed [CW-1:0] tgt_r [3];
  logic signed [CW-1:0] elb_r [3];
  logic signed [CW-1:0] tip_r [3];
  logic signed [CW-1:0] opa_r [3];
  logic signed [CW-1:0] opf_r [3];
  logic signed [CW-1:0] pnt_r [3];
  logic [CW-1:0] mag_r [3];
  logic [2:0]    neg_r;
  logic [LW-1:0] olen_r;
  logic          tw_r;
  logic [CW-1:0] mx_r;
  logic [4:0]    k_r;
  logic [1:0]    idx_r;
  logic [59:0]   sq_r;
  logic [63:0]   acc_r, res_r;
  logic [5:0]    cnt_r;
  logic [DW-1:0] dist_r;
  logic [PW-1:0] prod_r;
  logic [DW:0]   rem_r;
  logic [QW-1:0] quo_r;
  logic          sat_r, reach_r, conv_r, outv_r;
  fik_pkg::out_t outd_r;

  logic [CW-1:0]   shifted;
  logic [29:0]     sq_in;
  logic [63:0]     rbit, rsum;
  logic [DW-1:0]   dval;
  logic [PW-1:0]   addend;
  logic [DW:0]     dtrial;
  logic [QW-1:0]   qsel;
  logic signed [CW-1:0] qc;

  function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v[CW-1:31] == '0 || v[CW-1:31] == '1) begin
      r = v[31:0];
    end else if (v[CW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  always_comb begin
    shifted = mx_r >> k_r;
    sq_in   = 30'(mag_r[idx_r] >> k_r);
    rbit    = ROOT_BIT >> {cnt_r[4:0], 1'b0};
    rsum    = res_r + rbit;
    dval    = DW'(res_r[30:0]) << k_r;
    addend  = olen_r[cnt_r[4:0]] ? (PW'(mag_r[idx_r]) << cnt_r[4:0]) : '0;
    dtrial  = {rem_r[DW-1:0], prod_r[QW-1]};
    qsel    = (sat_r || quo_r > QLIM) ? QLIM : quo_r;
    qc      = $signed(CW'(qsel));
  end

  assign busy      = (st_r != ST_IDLE);
  assign out_valid = outv_r;
  assign out_data  = outd_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len0_r <= LW'(655360);
      len1_r <= LW'(655360);
      tol_r  <= LW'(6554);
      lim_r  <= 8'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        fik_pkg::CFG_LEN0: len0_r <= cfg_data;
        fik_pkg::CFG_LEN1: len1_r <= cfg_data;
        fik_pkg::CFG_TOL:  tol_r  <= cfg_data;
        fik_pkg::CFG_LIM:  lim_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      step_r <= M_D0;
      outv_r <= 1'b0;
    end else begin
      outv_r <= (st_r == ST_OUT);
      case (st_r)
        ST_IDLE: begin
          if (start) begin
            tgt_r[0] <= CW'(in_data.target_x);
            tgt_r[1] <= CW'(in_data.target_y);
            tgt_r[2] <= CW'(in_data.target_z);
            step_r   <= M_D0;
            st_r     <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          st_r   <= ST_DIFF;
          tw_r   <= !(step_r inside {M_D0, M_G});
          olen_r <= (step_r inside {M_U1, M_P2}) ? len0_r : len1_r;
          for (int i = 0; i < 3; i++) begin
            case (step_r)
              M_U2: begin
                opa_r[i] <= elb_r[i];
                opf_r[i] <= tgt_r[i];
              end
              M_G: begin
                opa_r[i] <= tip_r[i];
                opf_r[i] <= tgt_r[i];
              end
              M_P1: begin
                opa_r[i] <= tip_r[i];
                opf_r[i] <= elb_r[i];
              end
              M_P2: begin
                opa_r[i] <= '0;
                opf_r[i] <= elb_r[i];
              end
              M_P3: begin
                opa_r[i] <= elb_r[i];
                opf_r[i] <= tip_r[i];
              end
              default: begin
                opa_r[i] <= '0;
                opf_r[i] <= tgt_r[i];
              end
            endcase
          end
        end
        ST_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= opf_r[i] < opa_r[i];
            mag_r[i] <= (opf_r[i] < opa_r[i]) ? CW'(opa_r[i] - opf_r[i])
                                              : CW'(opf_r[i] - opa_r[i]);
          end
          st_r <= ST_MAX;
        end
        ST_MAX: begin
          if (mag_r[0] >= mag_r[1] && mag_r[0] >= mag_r[2]) begin
            mx_r <= mag_r[0];
          end else if (mag_r[1] >= mag_r[2]) begin
            mx_r <= mag_r[1];
          end else begin
            mx_r <= mag_r[2];
          end
          k_r  <= '0;
          st_r <= ST_NORM;
        end
        ST_NORM: begin
          // shift until the largest component is below 2^30
          if (|shifted[CW-1:30]) begin
            k_r <= k_r + 5'd1;
          end else begin
            idx_r <= '0;
            acc_r <= '0;
            st_r  <= ST_SQ;
          end
        end
        ST_SQ: begin
          sq_r <= sq_in * sq_in;
          st_r <= ST_ACC;
        end
        ST_ACC: begin
          acc_r <= acc_r + 64'(sq_r);
          if (idx_r == 2'd2) begin
            res_r <= '0;
            cnt_r <= '0;
            st_r  <= ST_ROOT;
          end else begin
            idx_r <= idx_r + 2'd1;
            st_r  <= ST_SQ;
          end
        end
        ST_ROOT: begin
          if (acc_r >= rsum) begin
            acc_r <= acc_r - rsum;
            res_r <= (res_r >> 1) + rbit;
          end else begin
            res_r <= res_r >> 1;
          end
          if (cnt_r[4:0] == 5'd31) begin
            st_r <= ST_DEND;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_DEND: begin
          dist_r <= dval;
          idx_r  <= '0;
          prod_r <= '0;
          cnt_r  <= '0;
          if (!tw_r) begin
            st_r <= ST_RET;
          end else if (dval == '0) begin
            // coincident points: place along +x
            pnt_r[0] <= opa_r[0] + CW'(olen_r);
            for (int i = 1; i < 3; i++) pnt_r[i] <= opa_r[i];
            st_r <= ST_RET;
          end else begin
            st_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r <= prod_r + addend;
          if (cnt_r[4:0] == 5'(LW - 1)) begin
            st_r <= ST_DVS;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_DVS: begin
          quo_r <= '0;
          cnt_r <= 6'(QW - 1);
          if (DW'(prod_r[PW-1:QW]) >= dist_r) begin
            sat_r <= 1'b1;
            st_r  <= ST_FIN;
          end else begin
            sat_r <= 1'b0;
            rem_r <= (DW+1)'(prod_r[PW-1:QW]);
            st_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dtrial >= {1'b0, dist_r}) begin
            rem_r <= dtrial - {1'b0, dist_r};
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= dtrial;
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          prod_r <= prod_r << 1;
          if (cnt_r == '0) begin
            st_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        ST_FIN: begin
          pnt_r[idx_r] <= neg_r[idx_r] ? opa_r[idx_r] - qc : opa_r[idx_r] + qc;
          prod_r <= '0;
          cnt_r  <= '0;
          if (idx_r == 2'd2) begin
            st_r <= ST_RET;
          end else begin
            idx_r <= idx_r + 2'd1;
            st_r  <= ST_MUL;
          end
        end
        ST_RET: begin
          case (step_r)
            M_D0: begin
              st_r    <= ST_LAUNCH;
              reach_r <= dist_r <= DW'(len0_r) + DW'(len1_r);
              if (dist_r <= DW'(len0_r) + DW'(len1_r)) begin
                elb_r[0] <= CW'(len0_r);
                tip_r[0] <= CW'(len0_r) + CW'(len1_r);
                for (int i = 1; i < 3; i++) begin
                  elb_r[i] <= '0;
                  tip_r[i] <= '0;
                end
                n_r    <= '0;
                step_r <= M_G;
              end else begin
                step_r <= M_U1;
              end
            end
            M_U1: begin
              for (int i = 0; i < 3; i++) elb_r[i] <= pnt_r[i];
              step_r <= M_U2;
              st_r   <= ST_LAUNCH;
            end
            M_U2: begin
              for (int i = 0; i < 3; i++) tip_r[i] <= pnt_r[i];
              conv_r <= 1'b0;
              st_r   <= ST_OUT;
            end
            M_G: begin
              if (dist_r > DW'(tol_r) && n_r < lim_r) begin
                for (int i = 0; i < 3; i++) tip_r[i] <= tgt_r[i];
                n_r    <= n_r + 8'd1;
                step_r <= M_P1;
                st_r   <= ST_LAUNCH;
              end else begin
                conv_r <= dist_r <= DW'(tol_r);
                st_r   <= ST_OUT;
              end
            end
            M_P1: begin
              for (int i = 0; i < 3; i++) elb_r[i] <= pnt_r[i];
              step_r <= M_P2;
              st_r   <= ST_LAUNCH;
            end
            M_P2: begin
              for (int i = 0; i < 3; i++) elb_r[i] <= pnt_r[i];
              step_r <= M_P3;
              st_r   <= ST_LAUNCH;
            end
            M_P3: begin
              for (int i = 0; i < 3; i++) tip_r[i] <= pnt_r[i];
              step_r <= M_G;
              st_r   <= ST_LAUNCH;
            end
            default: st_r <= ST_IDLE;
          endcase
        end
        ST_OUT: begin
          outd_r.elbow_x          <= sat32(elb_r[0]);
          outd_r.elbow_y          <= sat32(elb_r[1]);
          outd_r.elbow_z          <= sat32(elb_r[2]);
          outd_r.tip_x            <= sat32(tip_r[0]);
          outd_r.tip_y            <= sat32(tip_r[1]);
          outd_r.tip_z            <= sat32(tip_r[2]);
          outd_r.target_reachable <= reach_r;
          outd_r.converged        <= conv_r;
          st_r   <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the two-link FABRIK solver, with a built-in fixed-point predictor.
module testbench;
  import fik_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_LEN0;
  logic [30:0] cfg_data = '0;

  fabrik_two_link_ik_solver dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef longint pt_t [3];

  typedef struct {
    in_t  tgt;
    bit   typed;
    out_t pose;
  } dir_row_t;

  // shadow copy of the configuration registers
  bit [63:0] len0 = 64'd655360;
  bit [63:0] len1 = 64'd655360;
  bit [63:0] tol = 64'd6554;
  bit [63:0] max_passes = 64'd32;

  out_t pose_q[$];
  bit   failed = 1'b0;
  int   burst_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd12 * 64'd60_000_000);
    $display("fabrik_two_link_ik_solver: mismatch");
    $finish;
  end

  function automatic bit [63:0] umag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit [63:0] distance(pt_t a, pt_t b);
    bit [63:0] m [3];
    bit [63:0] mx;
    bit [63:0] s;
    bit [63:0] t;
    int k;
    mx = 0;
    s = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = umag(a[i] - b[i]);
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> k) >= (64'd1 << 30)) k++;
    for (int i = 0; i < 3; i++) begin
      t = m[i] >> k;
      s = s + t * t;
    end
    return int_sqrt(s) << k;
  endfunction

  // place a point len away from anchor, in the direction of src
  function automatic pt_t place_at(pt_t anchor, pt_t src, bit [63:0] len);
    pt_t o;
    bit [63:0] r;
    bit [127:0] q;
    longint d;
    r = distance(src, anchor);
    o = anchor;
    if (r == 0) begin
      o[0] = anchor[0] + longint'(len);
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      d = src[i] - anchor[i];
      q = (128'(umag(d)) * 128'(len)) / 128'(r);
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      o[i] = (d < 0) ? anchor[i] - longint'(q[63:0]) : anchor[i] + longint'(q[63:0]);
    end
    return o;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic out_t solve_ik(in_t t);
    pt_t root, tgt, elbow, tip;
    bit [63:0] gap;
    bit [63:0] n;
    bit reach, conv;
    out_t o;
    root = '{0, 0, 0};
    tgt = '{longint'(t.target_x), longint'(t.target_y), longint'(t.target_z)};
    conv = 1'b0;
    reach = distance(root, tgt) <= len0 + len1;
    if (!reach) begin
      elbow = place_at(root, tgt, len0);
      tip = place_at(elbow, tgt, len1);
    end else begin
      elbow = '{longint'(len0), 0, 0};
      tip = '{longint'(len0 + len1), 0, 0};
      gap = distance(tip, tgt);
      n = 0;
      while (gap > tol && n < max_passes) begin
        tip = tgt;
        elbow = place_at(tip, elbow, len1);
        elbow = place_at(root, elbow, len0);
        tip = place_at(elbow, tip, len1);
        gap = distance(tip, tgt);
        n++;
      end
      conv = gap <= tol;
    end
    o.elbow_x = sat32(elbow[0]);
    o.elbow_y = sat32(elbow[1]);
    o.elbow_z = sat32(elbow[2]);
    o.tip_x = sat32(tip[0]);
    o.tip_y = sat32(tip[1]);
    o.tip_z = sat32(tip[2]);
    o.target_reachable = reach;
    o.converged = conv;
    return o;
  endfunction

  // result checker: sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid) begin
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        failed = 1'b1;
      end else begin
        e = pose_q.pop_front();
        if (out_data.elbow_x !== e.elbow_x || out_data.elbow_y !== e.elbow_y ||
            out_data.elbow_z !== e.elbow_z || out_data.tip_x !== e.tip_x ||
            out_data.tip_y !== e.tip_y || out_data.tip_z !== e.tip_z ||
            out_data.target_reachable !== e.target_reachable ||
            out_data.converged !== e.converged) begin
          $display("%0t: expected elbow %0d %0d %0d tip %0d %0d %0d reach %b conv %b",
                   $time, e.elbow_x, e.elbow_y, e.elbow_z, e.tip_x, e.tip_y, e.tip_z,
                   e.target_reachable, e.converged);
          $display("%0t: actual   elbow %0d %0d %0d tip %0d %0d %0d reach %b conv %b",
                   $time, out_data.elbow_x, out_data.elbow_y, out_data.elbow_z,
                   out_data.tip_x, out_data.tip_y, out_data.tip_z,
                   out_data.target_reachable, out_data.converged);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic send_target(in_t v, bit typed, out_t pose);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
    end
    burst_left--;
    in_data <= v;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pose_q.push_back(typed ? pose : solve_ik(v));
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, bit [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_LEN0: len0 = 64'(val);
      CFG_LEN1: len1 = 64'(val);
      CFG_TOL:  tol = 64'(val);
      CFG_LIM:  max_passes = 64'(val[7:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord(bit [63:0] span);
    return 32'($signed(64'($urandom_range(0, 32'(2 * span)))) - longint'(span));
  endfunction

  function automatic in_t rand_target();
    in_t v;
    bit [63:0] span;
    int pick;
    pick = $urandom_range(0, 99);
    span = (len0 + len1) / 2;
    if (pick >= 60 && pick < 85) span = (len0 + len1) * 2 + 1;
    if (span > 64'd1073741823) span = 64'd1073741823;
    if (pick >= 85) begin
      v = {$urandom, $urandom, $urandom};
    end else begin
      v.target_x = rand_coord(span);
      v.target_y = rand_coord(span);
      v.target_z = rand_coord(span);
    end
    return v;
  endfunction

  initial begin
    dir_row_t tab [];
    out_t nil;
    nil = '0;
    tab = '{
      '{'{32'sd1310720, 0, 0}, 1'b1,
        '{32'sd655360, 0, 0, 32'sd1310720, 0, 0, 1'b1, 1'b1}},
      '{'{32'sd1307443, 0, 0}, 1'b1,
        '{32'sd655360, 0, 0, 32'sd1310720, 0, 0, 1'b1, 1'b1}},
      '{'{-32'sd1966080, 0, 0}, 1'b1,
        '{-32'sd655360, 0, 0, -32'sd1310720, 0, 0, 1'b0, 1'b0}},
      '{'{0, 32'sd2621440, 0}, 1'b1,
        '{0, 32'sd655360, 0, 0, 32'sd1310720, 0, 1'b0, 1'b0}},
      '{'{0, 0, 0}, 1'b0, nil},
      '{'{32'sd655360, 0, 0}, 1'b0, nil},
      '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 1'b0, nil},
      '{'{32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b0, nil},
      '{'{32'sh7FFFFFFF, 0, 0}, 1'b0, nil},
      '{'{32'sh80000000, 0, 0}, 1'b0, nil},
      '{'{0, 32'sh7FFFFFFF, 0}, 1'b0, nil},
      '{'{0, 0, 32'sh80000000}, 1'b0, nil},
      '{'{32'sd327680, 32'sd327680, 32'sd327680}, 1'b0, nil},
      '{'{0, -32'sd458752, 32'sd196608}, 1'b0, nil},
      '{'{-32'sd196608, 32'sd524288, -32'sd131072}, 1'b0, nil},
      '{'{32'sd1, -32'sd1, 32'sd1}, 1'b0, nil},
      '{'{32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F}, 1'b0, nil}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (tab[i]) send_target(tab[i].tgt, tab[i].typed, tab[i].pose);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      int cnt;
      case (ph)
        0: begin  // tolerance so wide that no pass ever runs
          write_reg(CFG_LEN0, 31'd327680);
          write_reg(CFG_LEN1, 31'd196608);
          write_reg(CFG_TOL, 31'h7FFFFFFF);
          write_reg(CFG_LIM, 31'd255);
          cnt = 60;
        end
        1: begin  // length extremes, far targets saturate
          write_reg(CFG_LEN0, 31'd1);
          write_reg(CFG_LEN1, 31'h7FFFFFFF);
          write_reg(CFG_TOL, 31'd0);
          write_reg(CFG_LIM, 31'd1);
          cnt = 60;
        end
        2: begin  // zero lengths, no passes allowed
          write_reg(CFG_LEN0, 31'd0);
          write_reg(CFG_LEN1, 31'd0);
          write_reg(CFG_TOL, 31'd100);
          write_reg(CFG_LIM, 31'd0);
          cnt = 40;
        end
        3: begin
          write_reg(CFG_LEN0, 31'($urandom_range(1, 1 << 20)));
          write_reg(CFG_LEN1, 31'($urandom_range(1, 1 << 20)));
          write_reg(CFG_TOL, 31'd6554);
          write_reg(CFG_LIM, 31'd2);
          cnt = 220;
        end
        4: begin
          write_reg(CFG_LEN0, 31'd1 << 30);
          write_reg(CFG_LEN1, 31'd12345678);
          write_reg(CFG_TOL, 31'd65536);
          write_reg(CFG_LIM, 31'd3);
          cnt = 60;
        end
        default: begin
          write_reg(CFG_LEN0, 31'd655360);
          write_reg(CFG_LEN1, 31'd655360);
          write_reg(CFG_TOL, 31'd6554);
          write_reg(CFG_LIM, 31'd6);
          cnt = 180;
        end
      endcase
      repeat (cnt) send_target(rand_target(), 1'b0, nil);
      drain();
    end
    repeat (100) @(posedge clk);
    if (!failed && pose_q.size() == 0) begin
      $display("fabrik_two_link_ik_solver: match");
    end else begin
      $display("fabrik_two_link_ik_solver: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/fik_pkg.sv
hw/rtl/fabrik_two_link_ik_solver.sv
sim/testbench.sv
